// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL of the priority queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Constants and types shared by the stable priority queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SCORE_W     = 32;
  localparam int TAG_W       = 8;
  localparam int OCC_W       = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Command broadcast to every cell of the row in the same cycle.
  typedef struct packed {
    logic                      do_insert;
    logic                      do_pop;
    logic signed [SCORE_W-1:0] new_score;
    logic        [TAG_W-1:0]   new_tag;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a score and a tag and trades them with
// its neighbors on insert and pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire  logic                      clk,
  input  wire  cell_ctrl_t                ctrl,
  input  wire  logic                      occupied,
  input  wire  logic                      left_keep,
  input  wire  logic signed [SCORE_W-1:0] left_score,
  input  wire  logic        [TAG_W-1:0]   left_tag,
  input  wire  logic signed [SCORE_W-1:0] right_score,
  input  wire  logic        [TAG_W-1:0]   right_tag,
  output logic                            keep,
  output logic signed [SCORE_W-1:0]       score,
  output logic        [TAG_W-1:0]         tag
);

  // A stored entry stays in place on insert when it ranks at or above the
  // new one; this keeps equal scores in arrival order.
  assign keep = occupied && (score >= ctrl.new_score);

  always_ff @(posedge clk) begin
    if (ctrl.do_insert) begin
      if (!keep) begin
        if (left_keep) begin
          score <= ctrl.new_score;
          tag   <= ctrl.new_tag;
        end else begin
          score <= left_score;
          tag   <= left_tag;
        end
      end
    end else if (ctrl.do_pop) begin
      score <= right_score;
      tag   <= right_tag;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue
// Fixed-depth priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one command per beat:
// operation 0 inserts entry_score/entry_tag, operation 1 pops the front.
// The output channel (out_valid/out_ready) returns one result beat per
// command: status, the popped front_score/front_tag (zero otherwise) and
// the occupancy after the command. Higher scores leave first; equal scores
// leave in arrival order. An insert into a full queue is dropped with
// status 1, a pop on an empty queue reports status 2.
// The result beat is valid in the cycle after the command is accepted.
// Every cell compares its score with the new one and moves in the same
// cycle, so a command can be accepted every cycle unless the receiver stalls:
// then the result register holds its beat and in_ready drops until it is
// taken. Reset empties the queue and clears the result valid flag; slot
// contents are not cleared and are never read while empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stable_priority_queue
  import spq_pkg::*;
(
  input  wire  logic                      clk,
  input  wire  logic                      rst,
  input  wire  logic                      in_valid,
  output logic                            in_ready,
  input  wire  logic                      operation,
  input  wire  logic signed [SCORE_W-1:0] entry_score,
  input  wire  logic        [TAG_W-1:0]   entry_tag,
  output logic                            out_valid,
  input  wire  logic                      out_ready,
  output logic        [1:0]               status,
  output logic signed [SCORE_W-1:0]       front_score,
  output logic        [TAG_W-1:0]         front_tag,
  output logic        [OCC_W-1:0]         occupancy
);

  logic             [CNT_W-1:0]   count;
  logic             [CNT_W-1:0]   count_next;
  logic                           accept;
  logic                           full;
  logic                           empty;
  cell_ctrl_t                     ctrl;

  logic signed [SCORE_W-1:0] cell_score [QUEUE_DEPTH];
  logic        [TAG_W-1:0]   cell_tag   [QUEUE_DEPTH];
  logic                      cell_keep  [QUEUE_DEPTH];

  // The result register frees up when its beat is taken.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign ctrl.do_insert = accept && (operation == OP_INSERT) && !full;
  assign ctrl.do_pop    = accept && (operation == OP_POP) && !empty;
  assign ctrl.new_score = entry_score;
  assign ctrl.new_tag   = entry_tag;

  always_comb begin
    count_next = count;
    if (ctrl.do_insert) begin
      count_next = count + 1'b1;
    end else if (ctrl.do_pop) begin
      count_next = count - 1'b1;
    end
  end

  // The row of cells. Cell 0 is the front. On insert every cell that keeps
  // its entry forms a prefix; the first cell after it takes the new entry
  // and the rest take their left neighbor's. On pop every cell but the back
  // one takes its right neighbor's entry; the back cell keeps its own.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                      occupied;
    logic                      left_keep;
    logic signed [SCORE_W-1:0] left_score;
    logic        [TAG_W-1:0]   left_tag;
    logic signed [SCORE_W-1:0] right_score;
    logic        [TAG_W-1:0]   right_tag;

    assign occupied = (CNT_W'(i) < count);

    if (i == 0) begin : g_front
      assign left_keep  = 1'b1;
      assign left_score = entry_score;
      assign left_tag   = entry_tag;
    end else begin : g_inner
      assign left_keep  = cell_keep[i-1];
      assign left_score = cell_score[i-1];
      assign left_tag   = cell_tag[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_back
      assign right_score = cell_score[i];
      assign right_tag   = cell_tag[i];
    end else begin : g_body
      assign right_score = cell_score[i+1];
      assign right_tag   = cell_tag[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied),
      .left_keep   (left_keep),
      .left_score  (left_score),
      .left_tag    (left_tag),
      .right_score (right_score),
      .right_tag   (right_tag),
      .keep        (cell_keep[i]),
      .score       (cell_score[i]),
      .tag         (cell_tag[i])
    );
  end

  // Count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= OCC_W'(count_next);
      if (operation == OP_INSERT) begin
        status      <= full ? ST_FULL : ST_DONE;
        front_score <= '0;
        front_tag   <= '0;
      end else if (empty) begin
        status      <= ST_EMPTY;
        front_score <= '0;
        front_tag   <= '0;
      end else begin
        status      <= ST_DONE;
        front_score <= cell_score[0];
        front_tag   <= cell_tag[0];
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `ASSERT_IMPLY(a_front_sorted, count >= CNT_W'(2), cell_score[0] >= cell_score[1], "front not sorted")
  `ASSERT_NEXT(a_insert_count, ctrl.do_insert, count == $past(count) + 1'b1, "insert count slip")
  `ASSERT_NEXT(a_empty_pop, accept && (operation == OP_POP) && empty, status == ST_EMPTY, "empty pop status")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for stable_priority_queue
// Inserts and pops are driven over valid/ready with random gaps on both
// sides. Every accepted command is mirrored in a software copy of the sorted
// queue, and every result beat is compared field by field with the oldest
// predicted result.
// ----------------------------------------------------------------------------

module tb;
  import spq_pkg::*;

  // Longest run of cycles without any beat before the run is declared hung.
  localparam int STALL_LIMIT     = 2000;
  // Length of the deliberate receiver stall that backs the block up.
  localparam int HOLD_OFF_CYCLES = 80;
  // Random traffic is cut into segments that each lean toward inserts, pops
  // or neither, so the queue swings between empty and full many times.
  localparam int SEGMENTS        = 26;
  localparam int SEGMENT_LEN     = 25;
  localparam int IDLE_PCT        = 22;

  // Opening inserts: the score extremes, zero and minus one, ties at the top,
  // at the bottom and in the middle, and alternating bit patterns. Sixteen of
  // them fill the queue exactly.
  localparam logic [SCORE_W-1:0] OPENING_SCORES [16] = '{
    32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
    32'h0000_0001, 32'hFFFF_FFFE, 32'h4000_0000, 32'hC000_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0064, 32'hFFFF_FF9C
  };
  localparam logic [TAG_W-1:0] OPENING_TAGS [16] = '{
    8'h01, 8'h02, 8'hFF, 8'h00, 8'h10, 8'hFE, 8'h01, 8'h03,
    8'h20, 8'h21, 8'h40, 8'h41, 8'hAA, 8'h55, 8'h80, 8'h7F
  };

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct {
    logic        [1:0]         status;
    logic signed [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;
    logic        [OCC_W-1:0]   occupancy;
  } result_t;

  // Keeps its own sorted copy of the queue and the results still owed by
  // the block, oldest first.
  class spq_scoreboard;
    entry_t  ranked[$];
    result_t awaited[$];
    int      beats_checked;
    int      failures;

    function void note_command(logic op, logic signed [SCORE_W-1:0] score,
                               logic [TAG_W-1:0] tag);
      result_t r;
      entry_t  e;
      int      pos;
      r.status = ST_DONE;
      r.score  = '0;
      r.tag    = '0;
      if (op == OP_INSERT) begin
        if (ranked.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Walk up past every strictly lower entry; equal scores stay ahead.
          pos = ranked.size();
          while (pos > 0 && ranked[pos-1].score < score) pos--;
          e.score = score;
          e.tag   = tag;
          ranked.insert(pos, e);
        end
      end else if (ranked.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e       = ranked.pop_front();
        r.score = e.score;
        r.tag   = e.tag;
      end
      r.occupancy = OCC_W'(ranked.size());
      awaited.push_back(r);
    endfunction

    task report_mismatch(string what, logic [SCORE_W-1:0] got,
                         logic [SCORE_W-1:0] want);
      $display("ERROR at %0t: result beat %0d, %s is %0h, expected %0h",
               $time, beats_checked, what, got, want);
      failures++;
    endtask

    task check_result(logic [1:0] status, logic signed [SCORE_W-1:0] score,
                      logic [TAG_W-1:0] tag, logic [OCC_W-1:0] occupancy);
      result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("beat with no command pending, status", status, '0);
      end else begin
        want = awaited.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (score !== want.score) report_mismatch("front_score", score, want.score);
        if (tag !== want.tag) report_mismatch("front_tag", tag, want.tag);
        if (occupancy !== want.occupancy) begin
          report_mismatch("occupancy", occupancy, want.occupancy);
        end
      end
      beats_checked++;
    endtask
  endclass

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic                      operation   = OP_INSERT;
  logic signed [SCORE_W-1:0] entry_score = '0;
  logic        [TAG_W-1:0]   entry_tag   = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic        [1:0]         status;
  logic signed [SCORE_W-1:0] front_score;
  logic        [TAG_W-1:0]   front_tag;
  logic        [OCC_W-1:0]   occupancy;

  // Set by the stimulus: no_idle_stretch turns off the random gaps on both
  // sides, hold_off_request asks the receiver for one long stall.
  bit no_idle_stretch  = 1'b0;
  bit hold_off_request = 1'b0;

  spq_scoreboard sb = new();

  stable_priority_queue dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .entry_score (entry_score),
    .entry_tag   (entry_tag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .front_score (front_score),
    .front_tag   (front_tag),
    .occupancy   (occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one command and returns at the edge where it is taken. A random
  // gap may come first; valid is only dropped when such a gap is taken, so a
  // back-to-back command keeps valid high and just swaps the payload. Each
  // idle cycle is drawn on its own, so about one cycle in five stays idle.
  task automatic send_command(logic op, logic signed [SCORE_W-1:0] score,
                              logic [TAG_W-1:0] tag);
    while (!no_idle_stretch && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    entry_score <= score;
    entry_tag   <= tag;
    // All of the block's outputs settle after the edge, so reading in_ready
    // right after waking gives the value the edge itself saw.
    do @(posedge clk); while (!in_ready);
    sb.note_command(op, score, tag);
  endtask

  initial begin : stimulus
    int                        insert_pct;
    logic                      op;
    logic signed [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: pop on the empty queue, fill it to the brim with
    // extremes and ties, try one insert into the full queue, then pop a few
    // to see the ties leave in arrival order.
    send_command(OP_POP, '0, '0);
    for (int i = 0; i < 16; i++) begin
      send_command(OP_INSERT, OPENING_SCORES[i], OPENING_TAGS[i]);
    end
    send_command(OP_INSERT, 32'sh7FFF_FFFF, 8'h77);
    repeat (5) send_command(OP_POP, SCORE_W'($urandom), TAG_W'($urandom));

    // Random traffic. Inserts get tie-prone small scores, extremes or fully
    // random words; the pop payload is random and must be ignored.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      no_idle_stretch = (seg == 8);
      if (seg == 4 || seg == 17) hold_off_request = 1'b1;
      case (seg % 3)
        0:       insert_pct = 80;
        1:       insert_pct = 20;
        default: insert_pct = 50;
      endcase
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
        case ($urandom_range(3))
          0: score = SCORE_W'($urandom_range(6)) - 3;
          1: begin
            case ($urandom_range(3))
              0:       score = 32'sh7FFF_FFFF;
              1:       score = 32'sh8000_0000;
              2:       score = '0;
              default: score = '1;
            endcase
          end
          default: score = SCORE_W'($urandom);
        endcase
        tag = TAG_W'($urandom);
        send_command(op, score, tag);
      end
    end
    no_idle_stretch = 1'b0;
    in_valid <= 1'b0;

    // Drain: every predicted result must come back, then a short tail
    // catches any extra beat.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: checks each beat it takes, then picks out_ready for the next
  // cycle. A hold-off keeps it low while the sender keeps
  // offering, so the result register fills and in_ready drops.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(status, front_score, front_tag, occupancy);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle_stretch || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a beat.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no beat moved in %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
tb/tb.sv
